[hw/rtl/hra_pkg.sv]
// shared types and constants for the hashed region allocator
package hra_pkg;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PLACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_MATCH = 2'd3;

  localparam logic [31:0] SEED_RESET = 32'd2147483647;

  localparam logic REG_BASE_PAGE  = 1'b0;
  localparam logic REG_POOL_PAGES = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] size_bytes;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] region_address;
    logic [19:0] freed_first_page;
    logic [20:0] freed_end_page;
    logic        legitimate;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_HASH, S_MULT, S_MOD, S_SCAN, S_PLACE,
    S_REL_SCAN, S_QRY_SCAN, S_CLEAR, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture accepted item
    logic hash_step;   // seed squared, registered
    logic hash_finish; // seed add and start divider
    logic mod_step;    // one quotient bit
    logic mod_done_to_cand; // form candidate
    logic scan_start;  // reset slot index
    logic scan_step;   // one slot per cycle
    logic place;       // write new range
    logic release_hit; // clear matched slot
    logic clear_step;  // table clear sweep
    logic clear_start;
    logic set_result;
    logic [1:0] res_status;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic too_big;
    logic mod_done;
    logic scan_last;
    logic scan_hit;     // overlap, match or containment found
    logic free_found;   // a free slot has been seen
    logic attempts_left;
    logic clear_last;
  } sts_t;

endpackage

[hw/rtl/hra_ctrl.sv]
// command sequencer for the hashed region allocator
module hra_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic [1:0]    cmd,
  input  logic          clear_req,
  input  logic          out_busy,
  input  hra_pkg::sts_t sts,
  output hra_pkg::ctl_t ctl,
  output logic          idle,
  output logic          done
);
  import hra_pkg::*;

  state_t state, state_next;
  logic [1:0] cmd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cmd_q <= CMD_ALLOC;
    end else begin
      state <= state_next;
      if (in_fire) cmd_q <= cmd;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (clear_req) state_next = S_CLEAR;
        else if (in_fire) state_next = S_CHECK;
      end
      S_CHECK: begin
        unique case (cmd_q)
          CMD_ALLOC:   state_next = sts.too_big ? S_DONE : S_HASH;
          CMD_RELEASE: state_next = S_REL_SCAN;
          CMD_QUERY:   state_next = S_QRY_SCAN;
          default:     state_next = S_DONE;
        endcase
      end
      S_HASH: state_next = S_MULT;
      S_MULT: state_next = S_MOD;
      S_MOD:  if (sts.mod_done) state_next = S_SCAN;
      S_SCAN: begin
        if (sts.scan_hit) state_next = sts.attempts_left ? S_HASH : S_DONE;
        else if (sts.scan_last) state_next = S_PLACE;
      end
      S_PLACE: state_next = S_DONE;
      S_REL_SCAN, S_QRY_SCAN: if (sts.scan_hit || sts.scan_last) state_next = S_DONE;
      S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
      S_DONE: if (!out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        ctl.load = in_fire;
        ctl.clear_start = clear_req;
      end
      S_CHECK: begin
        ctl.scan_start = 1'b1;
        if (cmd_q == CMD_ALLOC && sts.too_big) begin
          ctl.set_result = 1'b1;
          ctl.res_status = ST_NO_PLACE;
        end else if (cmd_q != CMD_ALLOC && cmd_q != CMD_RELEASE
                     && cmd_q != CMD_QUERY) begin
          ctl.set_result = 1'b1;
          ctl.res_status = ST_OK;
        end
      end
      S_HASH: ctl.hash_step = 1'b1;
      S_MULT: ctl.hash_finish = 1'b1;
      S_MOD: begin
        ctl.mod_step = 1'b1;
        ctl.mod_done_to_cand = sts.mod_done;
        ctl.scan_start = sts.mod_done;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_hit && !sts.attempts_left) begin
          ctl.set_result = 1'b1;
          ctl.res_status = ST_NO_PLACE;
        end
      end
      S_PLACE: begin
        ctl.place = sts.free_found;
        ctl.set_result = 1'b1;
        ctl.res_status = sts.free_found ? ST_OK : ST_FULL;
      end
      S_REL_SCAN: begin
        ctl.scan_step = 1'b1;
        ctl.release_hit = sts.scan_hit;
        if (sts.scan_hit || sts.scan_last) begin
          ctl.set_result = 1'b1;
          ctl.res_status = sts.scan_hit ? ST_OK : ST_NO_MATCH;
        end
      end
      S_QRY_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_last) begin
          ctl.set_result = 1'b1;
          ctl.res_status = ST_OK;
        end
      end
      S_CLEAR: ctl.clear_step = 1'b1;
      default: ;
    endcase
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> state == S_CLEAR) else $error("no clear pass after reset");
  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> state == S_IDLE) else $error("item loaded while busy");
  a_place_from_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_PLACE |-> $past(state) == S_SCAN) else $error("place without scan");
endmodule

[hw/rtl/hra_datapath.sv]
// table memory, hash, divider and scan logic
module hra_datapath #(
  parameter int TABLE_SLOTS  = 512,
  parameter int PAGE_SHIFT   = 12,
  parameter int MAX_ATTEMPTS = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  hra_pkg::ctl_t  ctl,
  input  hra_pkg::req_t  req,
  input  logic [19:0]    base_page,
  input  logic [20:0]    pool_pages,
  output hra_pkg::sts_t  sts,
  output hra_pkg::rsp_t  rsp
);
  import hra_pkg::*;

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int AW = $clog2(MAX_ATTEMPTS + 1);

  // table memory: start, end and valid mark per slot
  logic [19:0] mem_start [TABLE_SLOTS];
  logic [20:0] mem_end   [TABLE_SLOTS];
  logic        mem_valid [TABLE_SLOTS];

  req_t        rq;
  logic [31:0] seed;
  logic [63:0] sq;
  logic [20:0] npages;
  logic [31:0] dividend;
  logic [20:0] rem, modulus;
  logic [5:0]  div_cnt;
  logic [19:0] cs;
  logic [20:0] ce;
  logic [AW-1:0] attempts;
  logic [IW:0]   idx;
  logic [IW:0]   clr_idx;
  logic [IW-1:0] free_idx;
  logic          free_found;
  logic [19:0] rd_start;
  logic [20:0] rd_end;
  logic        rd_valid;
  logic [IW:0] rd_idx;
  logic        rd_live;
  rsp_t        rsp_next;

  logic [31-PAGE_SHIFT:0] page_full;
  logic [20:0] q_s, q_e, c_s, c_e;
  logic        ovl, hit;
  logic [21:0] trial;

  assign page_full = rq.address[31:PAGE_SHIFT];

  // overlap of read slot with the probe range
  always_comb begin
    c_s = {1'b0, rd_start};
    c_e = rd_end;
    if (rq.cmd == CMD_QUERY) begin
      q_s = 21'(page_full);
      q_e = q_s + 21'd1;
    end else begin
      q_s = {1'b0, cs};
      q_e = ce;
    end
    if (q_s < c_s) ovl = q_e > c_s;
    else           ovl = c_e > q_s;
    if (rq.cmd == CMD_RELEASE)
      hit = rd_live && rd_valid && (32'(rd_start) == 32'(page_full));
    else
      hit = rd_live && rd_valid && ovl;
  end

  assign trial = {rem, dividend[31]} - {1'b0, modulus};

  always_comb begin
    rsp_next = '0;
    rsp_next.status = ctl.res_status;
    if (ctl.res_status == ST_OK && rq.cmd == CMD_ALLOC)
      rsp_next.region_address = 32'({12'd0, cs} << PAGE_SHIFT);
    if (ctl.release_hit) begin
      rsp_next.freed_first_page = rd_start;
      rsp_next.freed_end_page   = rd_end;
    end
    if (rq.cmd == CMD_QUERY)
      rsp_next.legitimate = hit || (32'(page_full) == 32'(base_page));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
      rd_live <= 1'b0;
    end else begin
      rd_live <= ctl.scan_step && !idx[IW] && !ctl.scan_start && !ctl.set_result;
      if (ctl.hash_finish) seed <= sq[31:0] + {1'b0, seed[31:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_start) clr_idx <= '0;
    else if (ctl.clear_step) clr_idx <= clr_idx + 1'b1;
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.clear_step) begin
      // clear sweep, slot zero reserves the first pool page
      mem_valid[clr_idx[IW-1:0]] <= (clr_idx == '0);
      if (clr_idx == '0) begin
        mem_start[0] <= base_page;
        mem_end[0]   <= {1'b0, base_page} + 21'd1;
      end
    end else if (ctl.place) begin
      mem_start[free_idx] <= cs;
      mem_end[free_idx]   <= ce;
      mem_valid[free_idx] <= 1'b1;
    end else if (ctl.release_hit) begin
      mem_valid[rd_idx[IW-1:0]] <= 1'b0;
    end
    rd_start <= mem_start[idx[IW-1:0]];
    rd_end   <= mem_end[idx[IW-1:0]];
    rd_valid <= mem_valid[idx[IW-1:0]];
    rd_idx   <= idx;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rq <= req;
      attempts <= '0;
    end
    if (ctl.load)
      npages <= 21'(req.size_bytes >> PAGE_SHIFT)
              + 21'(|req.size_bytes[PAGE_SHIFT-1:0]);
    if (ctl.hash_step) begin
      sq <= seed * seed;
      attempts <= attempts + 1'b1;
    end
    if (ctl.hash_finish) begin
      dividend <= sq[31:0] + {1'b0, seed[31:1]};
      rem <= '0;
      div_cnt <= '0;
      modulus <= pool_pages - npages;
    end
    if (ctl.mod_step && !ctl.mod_done_to_cand) begin
      dividend <= {dividend[30:0], 1'b0};
      rem <= trial[21] ? {rem[19:0], dividend[31]} : trial[20:0];
      div_cnt <= div_cnt + 1'b1;
    end
    if (ctl.mod_done_to_cand) begin
      cs <= base_page + rem[19:0];
      ce <= {1'b0, base_page + rem[19:0]} + npages;
    end
    if (ctl.scan_start) begin
      idx <= '0;
      free_found <= 1'b0;
      free_idx <= '0;
    end else if (ctl.scan_step) begin
      if (!idx[IW]) idx <= idx + 1'b1;
      if (rd_live && !rd_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx <= rd_idx[IW-1:0];
      end
    end
    if (ctl.set_result) rsp <= rsp_next;
  end

  assign sts.too_big       = npages >= pool_pages;
  assign sts.mod_done      = div_cnt == 6'd32;
  assign sts.scan_last     = rd_live && (rd_idx == (IW+1)'(TABLE_SLOTS - 1));
  assign sts.scan_hit      = hit;
  assign sts.free_found    = free_found;
  assign sts.attempts_left = 32'(attempts) < MAX_ATTEMPTS;
  assign sts.clear_last    = clr_idx == (IW+1)'(TABLE_SLOTS - 1);

  a_place_has_free: assert property (@(posedge clk) disable iff (rst)
    ctl.place |-> free_found) else $error("place without free slot");
  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    ctl.mod_done_to_cand |-> rem < modulus) else $error("remainder out of range");
  a_one_table_write: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_step |-> !ctl.place && !ctl.release_hit) else $error("table write clash");
endmodule

[hw/rtl/hashed_region_allocator_top.sv]
// Hashed region allocator: takes one command item at a time and returns one
// result item. Release and query scan the slot table one slot per cycle.
// Allocate computes per candidate a hash and a bit-serial modulo, then scans
// the table, for up to MAX_ATTEMPTS candidates.
// The slot table is a memory with one write and one read port; the scan sets
// the pace. After reset and after each base_page write a clear pass
// rewrites the valid marks and reserves slot zero.
// Configuration writes are taken only while the block is idle.
module hashed_region_allocator_top #(
  parameter int TABLE_SLOTS  = 512,
  parameter int PAGE_SHIFT   = 12,
  parameter int MAX_ATTEMPTS = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  hra_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hra_pkg::rsp_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [0:0]     cfg_index,
  input  logic [20:0]    cfg_data
);
  import hra_pkg::*;

  ctl_t ctl;
  sts_t sts;
  rsp_t rsp;
  logic idle, done, in_fire, cfg_fire, clear_req;
  logic [19:0] base_page;
  logic [20:0] pool_pages;

  assign in_stall  = !idle || clear_req;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = idle;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign clear_req = cfg_fire && cfg_index == REG_BASE_PAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_page  <= '0;
      pool_pages <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_fire && cfg_index == REG_BASE_PAGE) base_page <= cfg_data[19:0];
      if (cfg_fire && cfg_index == REG_POOL_PAGES) pool_pages <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (done && !out_valid) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (done && !out_valid) out_data <= rsp;
  end

  hra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .cmd(in_data.cmd),
    .clear_req(clear_req), .out_busy(out_valid), .sts(sts), .ctl(ctl),
    .idle(idle), .done(done)
  );

  hra_datapath #(
    .TABLE_SLOTS(TABLE_SLOTS), .PAGE_SHIFT(PAGE_SHIFT), .MAX_ATTEMPTS(MAX_ATTEMPTS)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .req(in_data), .base_page(base_page),
    .pool_pages(pool_pages), .sts(sts), .rsp(rsp)
  );
endmodule
